/* design/tmp_pkg.sv */
`timescale 1ns / 1ps
// Package for the trapezoidal motion profiler.
// Holds the command codes, phase codes, sequencer states and helpers; no dependencies.
package tmp_pkg;

    typedef enum logic [2:0] {
        CMD_TICK   = 3'd0,
        CMD_START  = 3'd1,
        CMD_STOP   = 3'd2,
        CMD_FINISH = 3'd3,
        CMD_ADJUST = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_ACCEL = 2'd1,
        PH_DECEL = 2'd2,
        PH_DONE  = 2'd3
    } t_phase;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ_V,
        ST_SQ_F,
        ST_DIV,
        ST_DECIDE,
        ST_RAMP,
        ST_STEP,
        ST_INTEG,
        ST_OUTSTEP,
        ST_RESULT
    } t_state;

    // Divider handshake between the sequencer and the divider.
    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [32:0] den;
    } t_div_req;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [63:0] quo;
    } t_div_rsp;

    localparam int unsigned DIV_STEPS = 64;

    localparam logic signed [32:0] MAX_POS = 33'sd2147483647;
    localparam logic signed [32:0] MIN_NEG = -33'sd2147483648;

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        if (v > 34'(MAX_POS))      return 32'sh7fffffff;
        else if (v < 34'(MIN_NEG)) return 32'sh80000000;
        else                       return v[31:0];
    endfunction

    // Magnitude with -2^31 saturating to 2^31-1.
    function automatic logic [30:0] mag31(input logic signed [31:0] v);
        logic [31:0] m;
        m = v[31] ? 32'(-v) : 32'(v);
        if (m[31]) return 31'h7fffffff;
        else       return m[30:0];
    endfunction

endpackage

/* design/tmp_div.sv */
`timescale 1ns / 1ps
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on tmp_pkg for the request and response structs.
module tmp_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tmp_pkg::t_div_req i_req,
    output tmp_pkg::t_div_rsp o_rsp
);
    import tmp_pkg::*;

    logic [63:0] r_quo, n_quo;
    logic [32:0] r_den, n_den;
    logic [33:0] r_rem, n_rem;
    logic [6:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [33:0] shifted;
    logic [34:0] diff;

    always_comb begin
        shifted = {r_rem[32:0], r_quo[63]};
        diff    = {1'b0, shifted} - {2'b00, r_den};
        n_quo   = r_quo;
        n_den   = r_den;
        n_rem   = r_rem;
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        n_done  = 1'b0;
        if (i_req.start) begin
            n_quo  = i_req.num;
            n_den  = i_req.den;
            n_rem  = '0;
            n_cnt  = 7'(DIV_STEPS);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!diff[34]) begin
                n_rem = diff[33:0];
                n_quo = {r_quo[62:0], 1'b1};
            end else begin
                n_rem = shifted;
                n_quo = {r_quo[62:0], 1'b0};
            end
            n_cnt = r_cnt - 7'd1;
            if (r_cnt == 7'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_den <= n_den;
        r_rem <= n_rem;
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy)) else $error("divider done without run");
    a_cnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_busy && !i_req.start) |=> !r_busy) else $error("divider woke without start");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done || $past(i_req.start, 1)) else $error("done held");
endmodule

/* design/trapezoidal_motion_profiler.sv */
`timescale 1ns / 1ps
// Top level of the trapezoidal motion profiler: sequencer, state and shared multiplier.
// Depends on tmp_pkg and tmp_div.
//
//  channel | signals                         | direction
//  --------+---------------------------------+----------
//  request | i_valid/o_ready, i_mode..       | in
//  result  | o_valid/i_ready, o_current_*    | out
//  config  | i_cfg_we, i_cfg_idx, i_cfg_data | in
//
// A tick in a moving phase runs two squarings, a 64-step divide in the divider
// (skipped at zero acceleration), then ramp, step and output products on the one
// 33x17 multiplier. Other commands, and ticks while idle, go to the output step.
// Reset (synchronous, active low) clears all profile state to idle.
// A result waits in its output register until taken; no new request meanwhile.
module trapezoidal_motion_profiler (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [2:0]         i_mode,
    input  logic signed [31:0] i_move_distance,
    input  logic signed [31:0] i_speed_limit,
    input  logic signed [31:0] i_end_speed,
    input  logic signed [31:0] i_accel_rate,
    input  logic signed [31:0] i_position_offset,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_current_position,
    output logic signed [31:0] o_current_speed,
    output logic signed [31:0] o_step_distance,
    output logic signed [31:0] o_current_accel,
    output logic [1:0]         o_phase,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [30:0]        i_cfg_data
);
    import tmp_pkg::*;

    localparam logic CFG_TICK   = 1'b0;
    localparam logic CFG_THRESH = 1'b1;

    // configuration
    logic [15:0] r_tick;
    logic [30:0] r_thresh;

    // profile state
    logic signed [31:0] r_speed, n_speed;
    logic signed [31:0] r_pos, n_pos;
    logic [30:0]        r_goal, n_goal;
    logic signed [31:0] r_target, n_target;
    logic signed [31:0] r_close, n_close;
    logic signed [31:0] r_accel, n_accel;
    t_phase             r_phase, n_phase;
    logic               r_dirneg, n_dirneg;

    // sequencer
    t_state             r_state, n_state;
    logic [2:0]         r_mode;
    logic signed [31:0] r_offset;
    logic [63:0]        r_sqv, n_sqv;
    logic [63:0]        r_brake, n_brake;
    logic signed [32:0] r_remain, n_remain;
    logic signed [31:0] r_step, n_step;
    logic               r_ovalid, n_ovalid;

    // shared multiplier operands
    logic signed [32:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [49:0] mul_p;
    logic signed [31:0] sq_op;
    logic signed [65:0] sq_p;
    logic               sq_sel;

    t_div_req div_req;
    t_div_rsp div_rsp;

    tmp_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req),
        .o_rsp  (div_rsp)
    );

    logic [30:0] dist_mag, ms_mag, fs_mag, acc_mag, amag;
    logic [30:0] fs_clamp;
    logic [31:0] pos_mag;
    logic [63:0] dsq;
    logic signed [33:0] pos_sum;
    logic signed [33:0] spd_sum;
    logic [32:0] step_mag;

    assign dist_mag = mag31(i_move_distance);
    assign ms_mag   = mag31(i_speed_limit);
    assign fs_mag   = mag31(i_end_speed);
    assign acc_mag  = mag31(i_accel_rate);
    assign fs_clamp = (fs_mag > ms_mag) ? ms_mag : fs_mag;
    assign amag     = r_accel[31] ? 31'(-r_accel) : r_accel[30:0];
    assign pos_mag  = r_pos[31] ? 32'(-r_pos) : 32'(r_pos);

    // one multiplier for tick scaling: |accel| in the ramp state, speed elsewhere
    always_comb begin
        sq_sel = (r_state == ST_SQ_V) || (r_state == ST_SQ_F);
        mul_a  = 33'(r_speed);
        mul_b  = 17'($signed({1'b0, r_tick}));
        unique case (r_state)
            ST_RAMP: mul_a = 33'($signed({1'b0, amag}));
            default: mul_a = 33'(r_speed);
        endcase
    end
    // one squarer, operand picked by state
    assign sq_op = (r_state == ST_SQ_V) ? r_speed : r_close;
    assign sq_p  = sq_sel ? sq_op * sq_op : 66'sd0;
    assign mul_p = sq_sel ? 50'sd0 : mul_a * mul_b;

    assign dsq = (r_sqv > 64'(sq_p)) ? r_sqv - 64'(sq_p) : 64'(sq_p) - r_sqv;

    always_comb begin
        div_req.start = (r_state == ST_SQ_F) && (amag != 31'd0);
        div_req.num   = dsq;
        div_req.den   = {1'b0, amag, 1'b0};
    end

    // floor of speed * tick by 2^16; negative values round toward -inf
    always_comb begin
        step_mag = mul_p[49] ? 33'((-mul_p + 50'sd65535) >>> 16) : 33'(mul_p >>> 16);
        n_step   = mul_p[49] ? sat32(-34'($signed({1'b0, step_mag})))
                             : sat32(34'($signed({1'b0, step_mag})));
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:    if (i_valid) begin
                            if (i_mode == CMD_TICK && r_phase != PH_IDLE) n_state = ST_SQ_V;
                            else n_state = ST_OUTSTEP;
                        end
            ST_SQ_V:    n_state = ST_SQ_F;
            ST_SQ_F:    n_state = (amag == 31'd0) ? ST_DECIDE : ST_DIV;
            ST_DIV:     if (div_rsp.done) n_state = ST_DECIDE;
            ST_DECIDE:  n_state = ST_RAMP;
            ST_RAMP:    n_state = ST_STEP;
            ST_STEP:    n_state = ST_INTEG;
            ST_INTEG:   n_state = ST_OUTSTEP;
            ST_OUTSTEP: n_state = ST_RESULT;
            ST_RESULT:  if (r_ovalid && i_ready) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_speed  = r_speed;
        n_pos    = r_pos;
        n_goal   = r_goal;
        n_target = r_target;
        n_close  = r_close;
        n_accel  = r_accel;
        n_phase  = r_phase;
        n_dirneg = r_dirneg;
        n_sqv    = r_sqv;
        n_brake  = r_brake;
        n_remain = r_remain;
        n_ovalid = r_ovalid;
        pos_sum  = '0;
        spd_sum  = 34'(r_speed);
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    unique case (i_mode)
                        CMD_START: begin
                            n_dirneg = i_move_distance[31];
                            if (dist_mag < r_thresh && !(i_move_distance == 32'sh80000000)) begin
                                n_phase = PH_DONE;
                            end else begin
                                n_pos    = '0;
                                n_goal   = dist_mag;
                                n_target = i_move_distance[31] ? -32'($signed({1'b0, ms_mag}))
                                                               : 32'($signed({1'b0, ms_mag}));
                                n_close  = i_move_distance[31] ? -32'($signed({1'b0, fs_clamp}))
                                                               : 32'($signed({1'b0, fs_clamp}));
                                n_accel  = i_move_distance[31] ? -32'($signed({1'b0, acc_mag}))
                                                               : 32'($signed({1'b0, acc_mag}));
                                n_phase  = PH_ACCEL;
                            end
                        end
                        CMD_STOP: begin
                            n_target = '0;
                            n_speed  = '0;
                            n_phase  = PH_DONE;
                        end
                        CMD_FINISH: begin
                            n_speed = r_target;
                            n_phase = PH_DONE;
                        end
                        CMD_ADJUST: begin
                            pos_sum = 34'(r_pos) + 34'(i_position_offset);
                            n_pos   = sat32(pos_sum);
                        end
                        default: ;
                    endcase
                end
            end
            ST_SQ_V: begin
                n_sqv    = 64'(sq_p);
                n_remain = $signed({2'b00, r_goal}) - $signed({1'b0, pos_mag});
            end
            ST_SQ_F: n_brake = 64'(MAX_POS);
            ST_DIV: begin
                if (div_rsp.done)
                    n_brake = (div_rsp.quo > 64'(MAX_POS)) ? 64'(MAX_POS) : div_rsp.quo;
            end
            ST_DECIDE: begin
                if (r_phase == PH_ACCEL && r_remain <= $signed({1'b0, r_brake[31:0]})) begin
                    n_phase  = PH_DECEL;
                    n_target = r_close;
                end
            end
            ST_RAMP: begin
                // change = floor(|a| * tick / 2^16), fits in 31 bits
                if (r_speed < r_target) begin
                    spd_sum = 34'(r_speed) + 34'(mul_p >>> 16);
                    n_speed = (spd_sum > 34'(r_target)) ? r_target : spd_sum[31:0];
                end else if (r_speed > r_target) begin
                    spd_sum = 34'(r_speed) - 34'(mul_p >>> 16);
                    n_speed = (spd_sum < 34'(r_target)) ? r_target : spd_sum[31:0];
                end
            end
            ST_INTEG: begin
                pos_sum = 34'(r_pos) + 34'(r_step);
                n_pos   = sat32(pos_sum);
                if (r_phase != PH_DONE && r_remain < $signed({2'b00, r_thresh})) begin
                    n_phase  = PH_DONE;
                    n_target = r_close;
                end
            end
            ST_OUTSTEP: n_ovalid = 1'b1;
            ST_RESULT:  if (i_ready) n_ovalid = 1'b0;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_tick   <= 16'd66;
            r_thresh <= 31'd65536;
            r_speed  <= '0;
            r_pos    <= '0;
            r_goal   <= '0;
            r_target <= '0;
            r_close  <= '0;
            r_accel  <= '0;
            r_phase  <= PH_IDLE;
            r_dirneg <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_speed  <= n_speed;
            r_pos    <= n_pos;
            r_goal   <= n_goal;
            r_target <= n_target;
            r_close  <= n_close;
            r_accel  <= n_accel;
            r_phase  <= n_phase;
            r_dirneg <= n_dirneg;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_TICK:   r_tick   <= i_cfg_data[15:0];
                    CFG_THRESH: r_thresh <= i_cfg_data;
                    default: ;
                endcase
            end
        end
        if (r_state == ST_IDLE && i_valid) begin
            r_mode   <= i_mode;
            r_offset <= i_position_offset;
        end
        r_sqv    <= n_sqv;
        r_brake  <= n_brake;
        r_remain <= n_remain;
        if (r_state == ST_STEP || r_state == ST_OUTSTEP) r_step <= n_step;
    end

    assign o_ready            = (r_state == ST_IDLE);
    assign o_valid            = r_ovalid;
    assign o_current_position = r_pos;
    assign o_current_speed    = r_speed;
    assign o_step_distance    = r_step;
    assign o_current_accel    = r_accel;
    assign o_phase            = r_phase;

    a_no_ready_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready) else $error("ready while result pending");
    a_div_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.busy |-> r_state == ST_DIV) else $error("divider busy outside divide");
    a_idle_phase_still: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && i_valid && i_mode == CMD_TICK && r_phase == PH_IDLE)
        |=> r_state == ST_OUTSTEP) else $error("idle tick did work");
    a_mode_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |=> $stable(r_mode) && $stable(r_offset))
        else $error("request latched mid-item");
endmodule

/* tb/tb_trapezoidal_motion_profiler.sv */
`timescale 1ns / 1ps
// Self-checking testbench for trapezoidal_motion_profiler: directed table plus random moves.
// Depends on tmp_pkg and the profiler RTL; results are checked against an in-bench predictor or typed rows.
module tb_trapezoidal_motion_profiler;
    import tmp_pkg::*;

    // Spare command codes that the block must ignore.
    localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;
    // Configuration register indexes.
    localparam logic REG_TICK_PERIOD      = 1'b0;
    localparam logic REG_FINISH_THRESHOLD = 1'b1;

    localparam longint Q_MAX = 64'sd2147483647;
    localparam longint Q_MIN = -64'sd2147483648;
    // Settle time after a drain, well beyond the slowest moving tick.
    localparam int SETTLE_CYCLES = 200;

    typedef struct packed {
        logic signed [31:0] position;
        logic signed [31:0] speed;
        logic signed [31:0] step;
        logic signed [31:0] accel;
        t_phase             phase;
    } t_profile;

    typedef struct {
        logic [2:0]  mode;
        logic [31:0] travel;
        logic [31:0] vmax;
        logic [31:0] vend;
        logic [31:0] accel;
        logic [31:0] offset;
        bit          typed;
        t_profile    want;
    } t_vector;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic [2:0]         i_mode;
    logic signed [31:0] i_move_distance;
    logic signed [31:0] i_speed_limit;
    logic signed [31:0] i_end_speed;
    logic signed [31:0] i_accel_rate;
    logic signed [31:0] i_position_offset;
    logic               o_valid;
    logic               i_ready;
    logic signed [31:0] o_current_position;
    logic signed [31:0] o_current_speed;
    logic signed [31:0] o_step_distance;
    logic signed [31:0] o_current_accel;
    logic [1:0]         o_phase;
    logic               i_cfg_we;
    logic               i_cfg_idx;
    logic [30:0]        i_cfg_data;

    trapezoidal_motion_profiler u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_mode            (i_mode),
        .i_move_distance   (i_move_distance),
        .i_speed_limit     (i_speed_limit),
        .i_end_speed       (i_end_speed),
        .i_accel_rate      (i_accel_rate),
        .i_position_offset (i_position_offset),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_current_position(o_current_position),
        .o_current_speed   (o_current_speed),
        .o_step_distance   (o_step_distance),
        .o_current_accel   (o_current_accel),
        .o_phase           (o_phase),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data)
    );

    // Profile shadow: mirrors the block's registers, updated once per accepted request.
    longint   pf_speed, pf_pos, pf_goal, pf_target, pf_closing, pf_accel;
    t_phase   pf_phase;
    bit       pf_reverse;
    longint   pf_tick_period, pf_threshold;

    t_profile pending_profiles[$];
    t_vector  directed_rows[$];
    int       mismatches;
    int       send_gap_pct;   // chance, per cycle, that the request side holds off
    int       recv_stall_pct; // chance, per cycle, that the result side stalls
    int       random_left;

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // Safety net: far longer than the slowest legal run.
    initial begin
        #10_000_000;
        $display("trapezoidal_motion_profiler: mismatch");
        $finish;
    end

    function automatic longint mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint clamp_q(longint v);
        if (v > Q_MAX) return Q_MAX;
        if (v < Q_MIN) return Q_MIN;
        return v;
    endfunction

    // floor(v * tick_period / 2^16), rounding toward minus infinity
    function automatic longint scale_by_tick(longint v);
        longint p;
        p = v * pf_tick_period;
        if (p >= 0) return p >>> 16;
        return -((-p + 65535) >>> 16);
    endfunction

    // |vf^2 - v^2| / (2|a|), saturated; zero accel means brake at once
    function automatic longint brake_distance();
        longint num, den, q;
        num = mag(pf_closing * pf_closing - pf_speed * pf_speed);
        den = 2 * mag(pf_accel);
        if (den == 0) return Q_MAX;
        q = num / den;
        return q > Q_MAX ? Q_MAX : q;
    endfunction

    function automatic t_profile advance_profile(logic [2:0] mode, logic signed [31:0] travel,
                                                 logic signed [31:0] vmax,
                                                 logic signed [31:0] vend,
                                                 logic signed [31:0] accel,
                                                 logic signed [31:0] offset);
        longint   remaining, change, d, m, vm, ve, am, st;
        t_profile r;
        case (mode)
            CMD_TICK: begin
                if (pf_phase != PH_IDLE) begin
                    remaining = mag(pf_goal) - mag(pf_pos);
                    if (pf_phase == PH_ACCEL && remaining <= brake_distance()) begin
                        pf_phase  = PH_DECEL;
                        pf_target = pf_closing;
                    end
                    change = (mag(pf_accel) * pf_tick_period) >>> 16;
                    if (pf_speed < pf_target) begin
                        pf_speed += change;
                        if (pf_speed > pf_target) pf_speed = pf_target;
                    end else if (pf_speed > pf_target) begin
                        pf_speed -= change;
                        if (pf_speed < pf_target) pf_speed = pf_target;
                    end
                    pf_pos = clamp_q(pf_pos + scale_by_tick(pf_speed));
                    if (pf_phase != PH_DONE && remaining < pf_threshold) begin
                        pf_phase  = PH_DONE;
                        pf_target = pf_closing;
                    end
                end
            end
            CMD_START: begin
                d          = longint'(travel);
                pf_reverse = d < 0;
                m          = mag(d);
                if (m < pf_threshold) begin
                    // short move: record direction and mark the move done
                    pf_phase = PH_DONE;
                end else begin
                    vm = mag(longint'(vmax));
                    vm = vm > Q_MAX ? Q_MAX : vm;
                    ve = mag(longint'(vend));
                    ve = ve > Q_MAX ? Q_MAX : ve;
                    am = mag(longint'(accel));
                    am = am > Q_MAX ? Q_MAX : am;
                    if (ve > vm) ve = vm;
                    pf_pos     = 0;
                    pf_goal    = m > Q_MAX ? Q_MAX : m;
                    pf_target  = pf_reverse ? -vm : vm;
                    pf_closing = pf_reverse ? -ve : ve;
                    pf_accel   = pf_reverse ? -am : am;
                    pf_phase   = PH_ACCEL;
                end
            end
            CMD_STOP: begin
                pf_target = 0;
                pf_speed  = 0;
                pf_phase  = PH_DONE;
            end
            CMD_FINISH: begin
                pf_speed = pf_target;
                pf_phase = PH_DONE;
            end
            CMD_ADJUST: pf_pos = clamp_q(pf_pos + longint'(offset));
            default: ;
        endcase
        st         = clamp_q(scale_by_tick(pf_speed));
        r.position = pf_pos[31:0];
        r.speed    = pf_speed[31:0];
        r.step     = st[31:0];
        r.accel    = pf_accel[31:0];
        r.phase    = pf_phase;
        return r;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t: %s got %h, want %h", $realtime, what, got, want);
        mismatches++;
    endtask

    // Present one request, hold it until accepted, then queue its expected result.
    task automatic send_request(logic [2:0] mode, logic [31:0] travel, logic [31:0] vmax,
                                logic [31:0] vend, logic [31:0] accel, logic [31:0] offset,
                                bit typed, t_profile want);
        int       gap;
        t_profile predicted;
        gap = 0;
        while ($urandom_range(99) < send_gap_pct && gap < 40) gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid           <= 1'b1;
        i_mode            <= mode;
        i_move_distance   <= travel;
        i_speed_limit     <= vmax;
        i_end_speed       <= vend;
        i_accel_rate      <= accel;
        i_position_offset <= offset;
        do @(posedge i_clk); while (!o_ready);
        predicted = advance_profile(mode, travel, vmax, vend, accel, offset);
        pending_profiles.push_back(typed ? want : predicted);
    endtask

    task automatic send_plain(logic [2:0] mode, logic [31:0] travel, logic [31:0] vmax,
                              logic [31:0] vend, logic [31:0] accel, logic [31:0] offset);
        send_request(mode, travel, vmax, vend, accel, offset, 1'b0, '0);
        random_left--;
    endtask

    // Drop valid and wait until every result has come back and the block settles.
    task automatic drain();
        i_valid <= 1'b0;
        while (pending_profiles.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [30:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_TICK_PERIOD) pf_tick_period = value[15:0];
        else                        pf_threshold   = value;
    endtask

    task automatic add_row(logic [2:0] mode, logic [31:0] travel, logic [31:0] vmax,
                           logic [31:0] vend, logic [31:0] accel, logic [31:0] offset,
                           bit typed, logic [31:0] w_pos, logic [31:0] w_speed,
                           logic [31:0] w_step, logic [31:0] w_accel, t_phase w_phase);
        t_vector v;
        v.mode = mode; v.travel = travel; v.vmax = vmax; v.vend = vend;
        v.accel = accel; v.offset = offset; v.typed = typed;
        v.want = '{w_pos, w_speed, w_step, w_accel, w_phase};
        directed_rows.push_back(v);
    endtask

    // One well-formed move sized to finish in a few dozen ticks, with noise mixed in.
    task automatic random_move();
        longint travel, vmax, accel, period;
        int     ticks, k;
        logic [2:0] noise_mode;
        period = pf_tick_period == 0 ? 1 : pf_tick_period;
        ticks  = $urandom_range(45, 12);
        travel = longint'($urandom >> $urandom_range(14, 1)) + pf_threshold;
        travel = travel > Q_MAX ? Q_MAX : travel;
        vmax   = ((travel << 16) / (period * ticks)) + $urandom_range(255);
        vmax   = vmax > Q_MAX ? Q_MAX : vmax;
        accel  = ((vmax << 16) / (period * $urandom_range(ticks / 2, 1))) + $urandom_range(15);
        accel  = accel > Q_MAX ? Q_MAX : accel;
        if ($urandom_range(1)) travel = -travel;
        send_plain(CMD_START, travel[31:0],
                   $urandom_range(1) ? vmax[31:0] : -vmax[31:0],
                   $urandom_range(3) == 0 ? $urandom : ($urandom_range(1) ? vmax[31:0] >>
                       $urandom_range(8, 1) : -(vmax[31:0] >> $urandom_range(8, 1))),
                   $urandom_range(1) ? accel[31:0] : -accel[31:0], $urandom);
        for (k = 0; k < ticks + $urandom_range(10); k++) begin
            if ($urandom_range(99) < 8) begin
                // noise: any command, any payload, spare codes included
                noise_mode = 3'($urandom_range(CMD_SPARE_LAST));
                if (noise_mode == CMD_START && $urandom_range(1)) noise_mode = CMD_ADJUST;
                send_plain(noise_mode, $urandom, $urandom, $urandom, $urandom, $urandom);
            end else begin
                send_plain(CMD_TICK, $urandom, $urandom, $urandom, $urandom, $urandom);
            end
        end
    endtask

    // Result side: random stall on ready, compare every accepted result in order.
    initial begin
        t_profile want;
        i_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                if (pending_profiles.size() == 0) begin
                    report("unexpected result", o_current_position, '0);
                end else begin
                    want = pending_profiles.pop_front();
                    if (o_current_position !== want.position)
                        report("position", o_current_position, want.position);
                    if (o_current_speed !== want.speed)
                        report("speed", o_current_speed, want.speed);
                    if (o_step_distance !== want.step)
                        report("step", o_step_distance, want.step);
                    if (o_current_accel !== want.accel)
                        report("accel", o_current_accel, want.accel);
                    if (o_phase !== want.phase)
                        report("phase", 32'(o_phase), 32'(want.phase));
                end
            end
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Request side and run control.
    initial begin
        int     ph, n;
        longint periods[6];
        longint thresholds[6];
        int     gaps[6];
        int     stalls[6];
        int     budgets[6];
        i_rst_n = 1'b0; i_valid = 1'b0; i_mode = CMD_TICK;
        i_move_distance = '0; i_speed_limit = '0; i_end_speed = '0;
        i_accel_rate = '0; i_position_offset = '0;
        i_cfg_we = 1'b0; i_cfg_idx = REG_TICK_PERIOD; i_cfg_data = '0;
        mismatches = 0; send_gap_pct = 0; recv_stall_pct = 0;
        pf_speed = 0; pf_pos = 0; pf_goal = 0; pf_target = 0; pf_closing = 0; pf_accel = 0;
        pf_phase = PH_IDLE; pf_reverse = 1'b0; pf_tick_period = 66; pf_threshold = 65536;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table; typed rows carry results read straight from the spec.
        add_row(CMD_TICK, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, PH_IDLE);          // idle tick
        add_row(CMD_ADJUST, 0, 0, 0, 0, 32'h7fffffff, 1, 32'h7fffffff, 0, 0, 0, PH_IDLE);
        add_row(CMD_ADJUST, 0, 0, 0, 0, 32'h80000000, 1, 32'hffffffff, 0, 0, 0, PH_IDLE);
        add_row(CMD_ADJUST, 0, 0, 0, 0, 32'h80000000, 1, 32'h80000000, 0, 0, 0, PH_IDLE);
        add_row(CMD_SPARE_FIRST, '1, '1, '1, '1, '1, 1, 32'h80000000, 0, 0, 0, PH_IDLE);
        add_row(CMD_SPARE_LAST, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, PH_IDLE);
        // short move: below the finish threshold, only the phase changes
        add_row(CMD_START, 100, 5, 5, 5, 0, 1, 32'h80000000, 0, 0, 0, PH_DONE);
        add_row(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, PH_IDLE);
        // most negative inputs: magnitudes saturate, end speed clamps to the limit
        add_row(CMD_START, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h80000000, 0,
                1, 0, 0, 0, 32'h80000001, PH_ACCEL);
        repeat (4) add_row(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, PH_IDLE);
        add_row(CMD_STOP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, PH_IDLE);
        // zero acceleration: brakes on the first tick, speed holds
        add_row(CMD_START, 32'h7fffffff, 32'h03e80000, 32'h07d00000, 0, 0,
                0, 0, 0, 0, 0, PH_IDLE);
        repeat (2) add_row(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, PH_IDLE);
        add_row(CMD_FINISH, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, PH_IDLE);
        add_row(CMD_START, 32'h00100000, 32'h00200000, 0, 32'h00400000, 0,
                0, 0, 0, 0, 0, PH_IDLE);
        repeat (5) add_row(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, PH_IDLE);
        add_row(CMD_ADJUST, 0, 0, 0, 0, 32'hfff00000, 0, 0, 0, 0, 0, PH_IDLE);
        foreach (directed_rows[i])
            send_request(directed_rows[i].mode, directed_rows[i].travel,
                         directed_rows[i].vmax, directed_rows[i].vend,
                         directed_rows[i].accel, directed_rows[i].offset,
                         directed_rows[i].typed, directed_rows[i].want);
        drain();

        // Random phases: each sets both registers, then a handshake pattern.
        periods    = '{66, 1000, 65535, 1, 0, 300};
        thresholds = '{65536, 0, 2147483647, 1000, 65536, 4096};
        gaps       = '{0, 73, 0, 16, 0, 73};
        stalls     = '{0, 0, 73, 16, 0, 73};
        budgets    = '{220, 200, 80, 180, 50, 220};
        for (ph = 0; ph < 6; ph++) begin
            write_reg(REG_TICK_PERIOD, 31'(periods[ph]));
            write_reg(REG_FINISH_THRESHOLD, 31'(thresholds[ph]));
            send_gap_pct   = gaps[ph];
            recv_stall_pct = stalls[ph];
            random_left    = budgets[ph];
            n = 0;
            while (random_left > 0) begin
                random_move();
                n++;
                // hold off once until every outstanding result has returned
                if (ph == 5 && n == 2) begin
                    i_valid <= 1'b0;
                    while (pending_profiles.size() != 0) @(posedge i_clk);
                end
            end
            drain();
        end

        if (mismatches == 0 && pending_profiles.size() == 0)
            $display("trapezoidal_motion_profiler: match");
        else
            $display("trapezoidal_motion_profiler: mismatch");
        $finish;
    end

endmodule

/* filelist.f */
design/tmp_pkg.sv
design/tmp_div.sv
design/trapezoidal_motion_profiler.sv
tb/tb_trapezoidal_motion_profiler.sv
